// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the circle vote block.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CV_ASSERT_NEVER(label, clk, rst_n, cond) \
    `CV_ASSERT(label, clk, rst_n, !(cond))
`else
`define CV_ASSERT(label, clk, rst_n, prop)
`define CV_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/cvote_pkg.sv =====
// Widths, latencies, register indexes and status codes of the circle vote block.
// Used by the divider, the square root unit and the top level.
`default_nettype none

package cvote_pkg;

    localparam int COORD_W     = 10;
    localparam int FRAC_W      = 8;
    localparam int QUOT_INT_W  = 20;
    localparam int QUOT_W      = QUOT_INT_W + FRAC_W;
    localparam int NUM_W       = 3 * COORD_W + 3;
    localparam int DEN_W       = 2 * COORD_W + 3;
    localparam int ROOT_W      = 20;
    localparam int RSQ_W       = 2 * ROOT_W;
    localparam int DIV_LAT     = QUOT_W + 1;
    localparam int SQRT_LAT    = ROOT_W;
    localparam int FAR_PIXELS  = 2048;

    localparam int MINR_W      = 10;
    localparam int MAXR_W      = 11;
    localparam int SHIFT_W     = 3;
    localparam int BIN_W       = 13;
    localparam int RBIN_W      = 11;
    localparam int STATUS_W    = 2;

    localparam int IN_DATA_W   = ((6 * COORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((2 * BIN_W + RBIN_W + 7) / 8) * 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = MAXR_W;

    localparam logic [STATUS_W-1:0] ST_ACCEPT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COLLINEAR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RADIUS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RADIUS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_SHIFT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_SHIFT = 2'd3;

    localparam logic [MINR_W-1:0]  MIN_RADIUS_RST   = 10'd40;
    localparam logic [MAXR_W-1:0]  MAX_RADIUS_RST   = 11'd500;
    localparam logic [SHIFT_W-1:0] CENTER_SHIFT_RST = 3'd3;
    localparam logic [SHIFT_W-1:0] RADIUS_SHIFT_RST = 3'd3;

endpackage

`default_nettype wire

// ===== rtl/core/cvote_div.sv =====
// Pipelined restoring divider: floor(num * 2^FRAC_W / den), one quotient bit per stage.
// Depends on cvote_pkg for widths.
`default_nettype none

module cvote_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [cvote_pkg::NUM_W-1:0]  num,
    input  logic [cvote_pkg::DEN_W-1:0]  den,
    output logic [cvote_pkg::QUOT_W-1:0] quot,
    output logic                        far
);
    import cvote_pkg::*;

    localparam int REM_W = DEN_W + 1;
    localparam int CMP_W = DEN_W + QUOT_INT_W;

    logic [REM_W-1:0]  rem_reg  [0:QUOT_W];
    logic [QUOT_W-1:0] bits_reg [0:QUOT_W];
    logic [QUOT_W-1:0] quot_reg [0:QUOT_W];
    logic [DEN_W-1:0]  den_reg  [0:QUOT_W];
    logic              far_reg  [0:QUOT_W];

    // The quotient overflows its integer field exactly when num >= den * 2^QUOT_INT_W.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= REM_W'(num[NUM_W-1:QUOT_INT_W]);
            bits_reg[0] <= {num[QUOT_INT_W-1:0], FRAC_W'(0)};
            quot_reg[0] <= '0;
            den_reg[0]  <= den;
            far_reg[0]  <= CMP_W'(num) >= {den, QUOT_INT_W'(0)};
        end
    end

    for (genvar k = 1; k <= QUOT_W; k++) begin : g_step
        logic [REM_W-1:0] trial;
        logic             fits;

        assign trial = {rem_reg[k-1][REM_W-2:0], bits_reg[k-1][QUOT_W-1]};
        assign fits  = trial >= {1'b0, den_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= fits ? trial - {1'b0, den_reg[k-1]} : trial;
                bits_reg[k] <= {bits_reg[k-1][QUOT_W-2:0], 1'b0};
                quot_reg[k] <= {quot_reg[k-1][QUOT_W-2:0], fits};
                den_reg[k]  <= den_reg[k-1];
                far_reg[k]  <= far_reg[k-1];
            end
        end
    end

    assign quot = quot_reg[QUOT_W];
    assign far  = far_reg[QUOT_W];

endmodule

`default_nettype wire

// ===== rtl/core/cvote_sqrt.sv =====
// Pipelined integer square root, one result bit per stage (digit-by-digit method).
// Depends on cvote_pkg for widths.
`default_nettype none

module cvote_sqrt (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [cvote_pkg::RSQ_W-1:0]  rad_sq,
    output logic [cvote_pkg::ROOT_W-1:0] root
);
    import cvote_pkg::*;

    localparam int REM_W = ROOT_W + 4;

    logic [REM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];
    logic [RSQ_W-1:0]  val_reg  [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [RSQ_W-1:0]  val_prev;
        logic [REM_W-1:0]  rem_try;
        logic [REM_W-1:0]  cand;
        logic              fits;

        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign val_prev  = rad_sq;
        end else begin : g_later
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign val_prev  = val_reg[k-1];
        end

        assign rem_try = {rem_prev[REM_W-3:0], val_prev[RSQ_W-1 -: 2]};
        assign cand    = REM_W'({root_prev, 2'b01});
        assign fits    = rem_try >= cand;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= fits ? rem_try - cand : rem_try;
                root_reg[k] <= {root_prev[ROOT_W-2:0], fits};
                val_reg[k]  <= {val_prev[RSQ_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/three_point_circle_vote.sv =====
// Each vote passes the front stages, dividers, stages A to C, square root and final stage.
// One vote per cycle unless held; the 29-stage dividers and 20-stage square root set depth.
// The whole pipeline holds only when its last stage is full and both output slots are taken.
// Reset (aresetn low, synchronous) clears all valid bits, empties the output slots and
// loads the registers with min 40, max 500 and both shifts 3.
`default_nettype none
`include "assert_macros.svh"

module three_point_circle_vote (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input points. tdata from bit 0 up: first_x, first_y, second_x, second_y,
    // third_x, third_y, each COORD_W bits, zero filled to a whole byte.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cvote_pkg::IN_DATA_W-1:0]   s_tdata,
    // Votes. tdata from bit 0 up: center_x_bin, center_y_bin, radius_bin, zero filled.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cvote_pkg::OUT_DATA_W-1:0]  m_tdata,
    // tuser: vote_status.
    output logic [cvote_pkg::STATUS_W-1:0]    m_tuser,
    // Register writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cvote_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cvote_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cvote_pkg::*;

    // Stage count: four front stages, the divider, three after it, the root, one final.
    localparam int PIPE_LAT = 4 + DIV_LAT + 3 + SQRT_LAT + 1;
    localparam int CW1      = COORD_W + 1;
    localparam int SQ_W     = 2 * COORD_W + 1;
    localparam int PD_W     = 2 * COORD_W + 2;
    localparam int SD_W     = SQ_W + 1;
    localparam int DX_W     = QUOT_W + 2;
    localparam int SH_W     = 5;
    localparam logic signed [DX_W-1:0] FAR_LIM = DX_W'(FAR_PIXELS << FRAC_W);

    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic               col;
        logic               negx;
        logic               negy;
    } div_side_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BIN_W-1:0]    binx;
        logic [BIN_W-1:0]    biny;
    } root_side_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RBIN_W-1:0]   rbin;
        logic [BIN_W-1:0]    biny;
        logic [BIN_W-1:0]    binx;
    } vote_t;

    // ---------------------------------------------------------------- registers
    logic [MINR_W-1:0]    min_radius_reg;
    logic [MAXR_W-1:0]    max_radius_reg;
    logic [SHIFT_W-1:0]   center_shift_reg;
    logic [SHIFT_W-1:0]   radius_shift_reg;
    logic [2*MINR_W-1:0]  min_sq_reg;
    logic [2*MAXR_W-1:0]  max_sq_reg;

    // Writes never stall; the host must write only while no vote is in flight (not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_radius_reg   <= MIN_RADIUS_RST;
            max_radius_reg   <= MAX_RADIUS_RST;
            center_shift_reg <= CENTER_SHIFT_RST;
            radius_shift_reg <= RADIUS_SHIFT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIN_RADIUS:   min_radius_reg   <= cfg_data[MINR_W-1:0];
                REG_MAX_RADIUS:   max_radius_reg   <= cfg_data[MAXR_W-1:0];
                REG_CENTER_SHIFT: center_shift_reg <= cfg_data[SHIFT_W-1:0];
                REG_RADIUS_SHIFT: radius_shift_reg <= cfg_data[SHIFT_W-1:0];
            endcase
        end
    end

    // The squared limits follow the registers in the next cycle, well before a vote that
    // enters after the write can reach the compare stage.
    always_ff @(posedge aclk) begin
        min_sq_reg <= (2*MINR_W)'(min_radius_reg) * (2*MINR_W)'(min_radius_reg);
        max_sq_reg <= (2*MAXR_W)'(max_radius_reg) * (2*MAXR_W)'(max_radius_reg);
    end

    // ---------------------------------------------------------------- flow control
    // All stages move together. The output side has two slots, so the pipeline
    // keeps going while one finished vote waits to be taken.
    logic [PIPE_LAT-1:0] vld_reg;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic                pipe_adv;
    logic                push;
    logic                pop;

    assign pipe_adv = !(vld_reg[PIPE_LAT-1] && (cnt_reg == 2'd2));
    assign s_tready = pipe_adv;
    assign push     = pipe_adv && vld_reg[PIPE_LAT-1];
    assign pop      = m_tvalid && m_tready;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (pipe_adv) begin
                vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
            end
            cnt_reg <= cnt_next;
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Coordinate differences relative to the first point and the squared norms.
    logic [COORD_W-1:0] in_x1, in_y1, in_x2, in_y2, in_x3, in_y3;

    assign in_x1 = s_tdata[COORD_W-1:0];
    assign in_y1 = s_tdata[2*COORD_W-1:COORD_W];
    assign in_x2 = s_tdata[3*COORD_W-1:2*COORD_W];
    assign in_y2 = s_tdata[4*COORD_W-1:3*COORD_W];
    assign in_x3 = s_tdata[5*COORD_W-1:4*COORD_W];
    assign in_y3 = s_tdata[6*COORD_W-1:5*COORD_W];

    logic signed [CW1-1:0] s1_dx21_reg, s1_dy21_reg, s1_dx31_reg, s1_dy31_reg;
    logic [SQ_W-1:0]       s1_sq1_reg, s1_sq2_reg, s1_sq3_reg;
    logic [COORD_W-1:0]    s1_x1_reg, s1_y1_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            s1_dx21_reg <= $signed({1'b0, in_x2}) - $signed({1'b0, in_x1});
            s1_dy21_reg <= $signed({1'b0, in_y2}) - $signed({1'b0, in_y1});
            s1_dx31_reg <= $signed({1'b0, in_x3}) - $signed({1'b0, in_x1});
            s1_dy31_reg <= $signed({1'b0, in_y3}) - $signed({1'b0, in_y1});
            s1_sq1_reg  <= SQ_W'(in_x1) * SQ_W'(in_x1) + SQ_W'(in_y1) * SQ_W'(in_y1);
            s1_sq2_reg  <= SQ_W'(in_x2) * SQ_W'(in_x2) + SQ_W'(in_y2) * SQ_W'(in_y2);
            s1_sq3_reg  <= SQ_W'(in_x3) * SQ_W'(in_x3) + SQ_W'(in_y3) * SQ_W'(in_y3);
            s1_x1_reg   <= in_x1;
            s1_y1_reg   <= in_y1;
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic signed [PD_W-1:0] s2_p1_reg, s2_p2_reg;
    logic signed [SD_W-1:0] s2_s21_reg, s2_s31_reg;
    logic signed [CW1-1:0]  s2_dx21_reg, s2_dy21_reg, s2_dx31_reg, s2_dy31_reg;
    logic [COORD_W-1:0]     s2_x1_reg, s2_y1_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            s2_p1_reg   <= PD_W'(s1_dx21_reg * s1_dy31_reg);
            s2_p2_reg   <= PD_W'(s1_dx31_reg * s1_dy21_reg);
            s2_s21_reg  <= $signed({1'b0, s1_sq2_reg}) - $signed({1'b0, s1_sq1_reg});
            s2_s31_reg  <= $signed({1'b0, s1_sq3_reg}) - $signed({1'b0, s1_sq1_reg});
            s2_dx21_reg <= s1_dx21_reg;
            s2_dy21_reg <= s1_dy21_reg;
            s2_dx31_reg <= s1_dx31_reg;
            s2_dy31_reg <= s1_dy31_reg;
            s2_x1_reg   <= s1_x1_reg;
            s2_y1_reg   <= s1_y1_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3
    // Determinant and the four products of the centre numerators.
    logic signed [DEN_W-1:0] s3_d_reg;
    logic signed [NUM_W-1:0] s3_a_reg, s3_b_reg, s3_c_reg, s3_e_reg;
    logic [COORD_W-1:0]      s3_x1_reg, s3_y1_reg;

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            s3_d_reg  <= DEN_W'(s2_p1_reg) - DEN_W'(s2_p2_reg);
            s3_a_reg  <= NUM_W'(s2_s21_reg * s2_dy31_reg);
            s3_b_reg  <= NUM_W'(s2_s31_reg * s2_dy21_reg);
            s3_c_reg  <= NUM_W'(s2_s31_reg * s2_dx21_reg);
            s3_e_reg  <= NUM_W'(s2_s21_reg * s2_dx31_reg);
            s3_x1_reg <= s2_x1_reg;
            s3_y1_reg <= s2_y1_reg;
        end
    end

    // ---------------------------------------------------------------- stage 4
    // Magnitudes and signs for the dividers; the divisor is 2|D|.
    logic signed [NUM_W:0]   nx_c, ny_c, nx_mag, ny_mag;
    logic signed [DEN_W-1:0] d_mag;
    logic [NUM_W-1:0]        s4_unx_reg, s4_uny_reg;
    logic [DEN_W-1:0]        s4_ud_reg;
    div_side_t               s4_side_reg;

    always_comb begin
        nx_c   = (NUM_W+1)'(s3_a_reg) - (NUM_W+1)'(s3_b_reg);
        ny_c   = (NUM_W+1)'(s3_c_reg) - (NUM_W+1)'(s3_e_reg);
        nx_mag = nx_c[NUM_W] ? -nx_c : nx_c;
        ny_mag = ny_c[NUM_W] ? -ny_c : ny_c;
        d_mag  = s3_d_reg[DEN_W-1] ? -s3_d_reg : s3_d_reg;
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            s4_unx_reg       <= nx_mag[NUM_W-1:0];
            s4_uny_reg       <= ny_mag[NUM_W-1:0];
            s4_ud_reg        <= {d_mag[DEN_W-2:0], 1'b0};
            s4_side_reg.x1   <= s3_x1_reg;
            s4_side_reg.y1   <= s3_y1_reg;
            s4_side_reg.col  <= (s3_d_reg == '0);
            s4_side_reg.negx <= nx_c[NUM_W] ^ s3_d_reg[DEN_W-1];
            s4_side_reg.negy <= ny_c[NUM_W] ^ s3_d_reg[DEN_W-1];
        end
    end

    // ---------------------------------------------------------------- dividers
    logic [QUOT_W-1:0] qx, qy;
    logic              farx, fary;
    div_side_t         dside_reg [0:DIV_LAT-1];

    cvote_div u_div_x (
        .aclk (aclk),
        .en   (pipe_adv),
        .num  (s4_unx_reg),
        .den  (s4_ud_reg),
        .quot (qx),
        .far  (farx)
    );

    cvote_div u_div_y (
        .aclk (aclk),
        .en   (pipe_adv),
        .num  (s4_uny_reg),
        .den  (s4_ud_reg),
        .quot (qy),
        .far  (fary)
    );

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            dside_reg[0] <= s4_side_reg;
        end
    end

    for (genvar k = 1; k < DIV_LAT; k++) begin : g_dside
        always_ff @(posedge aclk) begin
            if (pipe_adv) begin
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- stage A
    // Signed centre and its offset from the first point, both in fixed point.
    div_side_t              dsd;
    logic signed [QUOT_W:0] cx, cy;
    logic signed [DX_W-1:0] a_dx_reg, a_dy_reg;
    logic [QUOT_W-1:0]      a_qx_reg, a_qy_reg;
    logic                   a_negx_reg, a_negy_reg, a_col_reg, a_far_reg;

    assign dsd = dside_reg[DIV_LAT-1];

    always_comb begin
        cx = dsd.negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        cy = dsd.negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            a_dx_reg   <= DX_W'(cx) - $signed(DX_W'({dsd.x1, FRAC_W'(0)}));
            a_dy_reg   <= DX_W'(cy) - $signed(DX_W'({dsd.y1, FRAC_W'(0)}));
            a_qx_reg   <= qx;
            a_qy_reg   <= qy;
            a_negx_reg <= dsd.negx;
            a_negy_reg <= dsd.negy;
            a_col_reg  <= dsd.col;
            a_far_reg  <= farx || fary;
        end
    end

    // ---------------------------------------------------------------- stage B
    // Squared offsets, far-centre check and the centre bins.
    logic signed [ROOT_W-1:0]  dxs, dys;
    logic signed [RSQ_W-1:0]   sqx, sqy;
    logic [SH_W-1:0]           csh;
    logic [QUOT_W-1:0]         magx, magy;
    logic [RSQ_W-1:0]          b_sqx_reg, b_sqy_reg;
    logic [BIN_W-1:0]          b_binx_reg, b_biny_reg;
    logic                      b_col_reg, b_far_reg;

    always_comb begin
        dxs  = a_dx_reg[ROOT_W-1:0];
        dys  = a_dy_reg[ROOT_W-1:0];
        sqx  = RSQ_W'(dxs * dxs);
        sqy  = RSQ_W'(dys * dys);
        csh  = SH_W'(FRAC_W) + SH_W'(center_shift_reg);
        magx = a_qx_reg >> csh;
        magy = a_qy_reg >> csh;
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            b_sqx_reg  <= $unsigned(sqx);
            b_sqy_reg  <= $unsigned(sqy);
            b_binx_reg <= a_negx_reg ? -BIN_W'(magx) : BIN_W'(magx);
            b_biny_reg <= a_negy_reg ? -BIN_W'(magy) : BIN_W'(magy);
            b_col_reg  <= a_col_reg;
            b_far_reg  <= a_far_reg
                          || (a_dx_reg >= FAR_LIM) || (a_dx_reg <= -FAR_LIM)
                          || (a_dy_reg >= FAR_LIM) || (a_dy_reg <= -FAR_LIM);
        end
    end

    // ---------------------------------------------------------------- stage C
    // Squared radius against the open window of squared limits.
    logic [RSQ_W-1:0]    r2, lo, hi;
    logic                in_win;
    logic [RSQ_W-1:0]    c_r2_reg;
    root_side_t          c_side_reg;

    always_comb begin
        r2     = b_sqx_reg + b_sqy_reg;
        lo     = RSQ_W'({min_sq_reg, (2*FRAC_W)'(0)});
        hi     = RSQ_W'({max_sq_reg, (2*FRAC_W)'(0)});
        in_win = (r2 > lo) && (r2 < hi);
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            c_r2_reg        <= r2;
            c_side_reg.binx <= b_binx_reg;
            c_side_reg.biny <= b_biny_reg;
            priority if (b_col_reg) begin
                c_side_reg.status <= ST_COLLINEAR;
            end else if (b_far_reg || !in_win) begin
                c_side_reg.status <= ST_RANGE;
            end else begin
                c_side_reg.status <= ST_ACCEPT;
            end
        end
    end

    // ---------------------------------------------------------------- square root
    logic [ROOT_W-1:0] root;
    root_side_t        rside_reg [0:SQRT_LAT-1];

    cvote_sqrt u_sqrt (
        .aclk   (aclk),
        .en     (pipe_adv),
        .rad_sq (c_r2_reg),
        .root   (root)
    );

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            rside_reg[0] <= c_side_reg;
        end
    end

    for (genvar k = 1; k < SQRT_LAT; k++) begin : g_rside
        always_ff @(posedge aclk) begin
            if (pipe_adv) begin
                rside_reg[k] <= rside_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- final stage
    // Radius bin, and every bin forced to zero unless the vote is accepted.
    root_side_t      rsd;
    logic [SH_W-1:0] rsh;
    logic [RBIN_W-1:0] rbin;
    logic            acc;
    vote_t           fin_reg;

    assign rsd  = rside_reg[SQRT_LAT-1];
    assign rsh  = SH_W'(FRAC_W) + SH_W'(radius_shift_reg);
    assign rbin = RBIN_W'(root >> rsh);
    assign acc  = (rsd.status == ST_ACCEPT);

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            fin_reg.status <= rsd.status;
            fin_reg.binx   <= acc ? rsd.binx : '0;
            fin_reg.biny   <= acc ? rsd.biny : '0;
            fin_reg.rbin   <= acc ? rbin : '0;
        end
    end

    // ---------------------------------------------------------------- output slots
    // out_reg drives the port; skid_reg takes a vote that arrives while out_reg waits.
    vote_t out_reg;
    vote_t skid_reg;

    always_ff @(posedge aclk) begin
        if (pop && (cnt_reg == 2'd2)) begin
            out_reg <= skid_reg;
        end else if (push && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop))) begin
            out_reg <= fin_reg;
        end
        if (push && (cnt_reg == 2'd1) && !pop) begin
            skid_reg <= fin_reg;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = out_reg.status;
    assign m_tdata  = OUT_DATA_W'({out_reg.rbin, out_reg.biny, out_reg.binx});

    // ---------------------------------------------------------------- assertions
    `CV_ASSERT_NEVER(a_cnt_range, aclk, aresetn, cnt_reg == 2'd3)
    `CV_ASSERT(a_stall_hold, aclk, aresetn, (!pipe_adv && vld_reg[PIPE_LAT-1]) |=> vld_reg[PIPE_LAT-1])
    `CV_ASSERT(a_ready_full, aclk, aresetn, !s_tready |-> (cnt_reg == 2'd2))
    `CV_ASSERT(a_reject_zero, aclk, aresetn, (m_tvalid && (m_tuser != ST_ACCEPT)) |-> (m_tdata == '0))

endmodule

`default_nettype wire

// ===== bench/tb_three_point_circle_vote.sv =====
// Self-checking bench for the three-point circle vote block.
// Depends on cvote_pkg and the three_point_circle_vote RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_three_point_circle_vote;
    import cvote_pkg::*;

    // A vote as it leaves the block: status plus the three cell indexes.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BIN_W-1:0]    cx_bin;
        logic [BIN_W-1:0]    cy_bin;
        logic [RBIN_W-1:0]   r_bin;
    } vote_t;

    typedef logic [COORD_W-1:0] coord_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    three_point_circle_vote uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // The predictor keeps its own copy of the four registers.
    longint unsigned min_r = 40, max_r = 500, cshift = 3, rshift = 3;

    logic [IN_DATA_W-1:0] point_queue[$];  // triples waiting to be sent
    vote_t                vote_queue[$];   // predicted votes, oldest first
    int                   error_count = 0;

    // Idling controls: random idling can be switched off, and the receiver can be
    // held off for a counted stretch while the sender keeps going. The stimulus
    // raises hold_reqs; the hold counter answers by loading hold_cycles.
    bit    idle_on = 1'b1;
    int    hold_reqs = 0;
    int    hold_done = 0;
    int    hold_cycles = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch in %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic add_points(input logic [IN_DATA_W-1:0] d);
        point_queue = {point_queue, d};
    endtask

    // Fixed-point quotient num*2^FRAC/den truncated toward zero; flags a far centre.
    function automatic longint center_quot(input longint num, input longint den,
                                           inout bit far);
        longint unsigned un, ud, q, r, mag;
        bit neg;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = un / ud;
        r = un % ud;
        if (q >= (64'd1 << QUOT_INT_W)) begin
            far = 1'b1;
            return 0;
        end
        mag = (q << FRAC_W) + ((r << FRAC_W) / ud);
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint cell_index(input longint v, input int s);
        if (v < 0) return -longint'(longint'(-v) >>> s);
        return v >>> s;
    endfunction

    // Circumcircle of three points turned into one expected vote.
    function automatic vote_t circle_vote(input logic [IN_DATA_W-1:0] d);
        longint x1, y1, x2, y2, x3, y3, det, s21, s31, nx, ny, cx, cy, dx, dy, lim;
        longint unsigned r2, lo, hi;
        bit far;
        vote_t v;
        v = '0;
        far = 1'b0;
        x1 = d[0*COORD_W +: COORD_W]; y1 = d[1*COORD_W +: COORD_W];
        x2 = d[2*COORD_W +: COORD_W]; y2 = d[3*COORD_W +: COORD_W];
        x3 = d[4*COORD_W +: COORD_W]; y3 = d[5*COORD_W +: COORD_W];
        lim = longint'(FAR_PIXELS) << FRAC_W;
        det = (x2 - x1) * (y3 - y1) - (x3 - x1) * (y2 - y1);
        if (det == 0) begin
            v.status = ST_COLLINEAR;
            return v;
        end
        s21 = x2 * x2 + y2 * y2 - x1 * x1 - y1 * y1;
        s31 = x3 * x3 + y3 * y3 - x1 * x1 - y1 * y1;
        nx = s21 * (y3 - y1) - s31 * (y2 - y1);
        ny = (x2 - x1) * s31 - (x3 - x1) * s21;
        cx = center_quot(nx, 2 * det, far);
        cy = center_quot(ny, 2 * det, far);
        v.status = ST_RANGE;
        if (far) return v;
        dx = cx - (x1 << FRAC_W);
        dy = cy - (y1 << FRAC_W);
        if (dx <= -lim || dx >= lim || dy <= -lim || dy >= lim) return v;
        r2 = dx * dx + dy * dy;
        lo = (min_r * min_r) << (2 * FRAC_W);
        hi = (max_r * max_r) << (2 * FRAC_W);
        if (!(r2 > lo && r2 < hi)) return v;
        v.status = ST_ACCEPT;
        v.cx_bin = BIN_W'(cell_index(cx, FRAC_W + int'(cshift)));
        v.cy_bin = BIN_W'(cell_index(cy, FRAC_W + int'(cshift)));
        v.r_bin = RBIN_W'(int_sqrt(r2) >> (FRAC_W + rshift));
        return v;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_points(input coord_t ax, ay, bx, by,
                                                         cx, cy);
        pack_points = '0;
        pack_points[6*COORD_W-1:0] = {cy, cx, by, bx, ay, ax};
    endfunction

    // Mostly realistic triples on a circle of random size, plus raw noise.
    function automatic logic [IN_DATA_W-1:0] random_points();
        int xc, yc, rad, k;
        coord_t p[6];
        real a;
        if ($urandom_range(0, 3) == 0) begin
            for (k = 0; k < 6; k++) p[k] = coord_t'($urandom);
        end else begin
            xc = $urandom_range(0, 1023);
            yc = $urandom_range(0, 1023);
            rad = $urandom_range(1, 600);
            for (k = 0; k < 3; k++) begin
                a = $urandom_range(0, 6283) / 1000.0;
                p[2*k] = coord_t'($rtoi(xc + rad * $cos(a)) & 1023);
                p[2*k+1] = coord_t'($rtoi(yc + rad * $sin(a)) & 1023);
            end
        end
        return pack_points(p[0], p[1], p[2], p[3], p[4], p[5]);
    endfunction

    // Driver: takes items from the pending queue, idles at random, 19 times in 100.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                vote_queue = {vote_queue, circle_vote(s_tdata)};
            end
            if (!s_tvalid || s_tready) begin
                if (point_queue.size() > 0 && !(idle_on && $urandom_range(0, 99) < 19)) begin
                    s_tdata <= point_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold counter: a stimulus request holds off the receiver until hold_cycles is 0.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (hold_done != hold_reqs) begin
            hold_done <= hold_reqs;
            hold_cycles <= 300;
        end
    end

    // Monitor: checks each vote against the oldest prediction, stalls at random.
    always @(posedge aclk) begin
        vote_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (vote_queue.size() == 0) begin
                    report_mismatch("unexpected vote status", m_tuser, -1);
                end else begin
                    want = vote_queue.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("vote_status", m_tuser, want.status);
                    if (m_tdata[0 +: BIN_W] !== want.cx_bin)
                        report_mismatch("center_x_bin", m_tdata[0 +: BIN_W], want.cx_bin);
                    if (m_tdata[BIN_W +: BIN_W] !== want.cy_bin)
                        report_mismatch("center_y_bin", m_tdata[BIN_W +: BIN_W],
                                        want.cy_bin);
                    if (m_tdata[2*BIN_W +: RBIN_W] !== want.r_bin)
                        report_mismatch("radius_bin", m_tdata[2*BIN_W +: RBIN_W],
                                        want.r_bin);
                end
            end
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(0, 99) < 19);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_RADIUS:   min_r = val & 10'h3FF;
            REG_MAX_RADIUS:   max_r = val & 11'h7FF;
            REG_CENTER_SHIFT: cshift = val & 3'h7;
            default:          rshift = val & 3'h7;
        endcase
    endtask

    // Waits until every item has been sent and every vote has come back.
    task automatic drain();
        while (point_queue.size() > 0 || s_tvalid || vote_queue.size() > 0)
            @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    task automatic queue_random(input int n);
        repeat (n) add_points(random_points());
    endtask

    initial begin
        int k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed triples at the reset settings.
        add_points(pack_points(0, 0, 0, 0, 0, 0));
        add_points(pack_points(1023, 1023, 1023, 1023, 1023, 1023));
        add_points(pack_points(0, 0, 10, 10, 20, 20));          // collinear
        add_points(pack_points(100, 100, 200, 100, 100, 200));  // accepted
        add_points(pack_points(0, 0, 1023, 0, 0, 1023));        // big circle
        add_points(pack_points(0, 1023, 1023, 0, 1023, 1023));
        add_points(pack_points(0, 0, 1, 0, 1023, 1));           // far centre
        add_points(pack_points(0, 0, 1023, 1, 0, 1));
        add_points(pack_points(500, 500, 501, 500, 500, 501));  // tiny radius
        add_points(pack_points(1023, 0, 0, 0, 1023, 1023));
        add_points(pack_points(340, 300, 300, 340, 260, 300));  // radius 40
        add_points(pack_points(341, 300, 300, 341, 259, 300));  // radius 41
        add_points(pack_points(0, 512, 1, 0, 1022, 1023));
        add_points(pack_points(682, 341, 341, 682, 0, 341));
        queue_random(100);
        drain();

        // Extremes of the registers, including an empty window and shifts of 7.
        write_reg(REG_MIN_RADIUS, 0);
        write_reg(REG_MAX_RADIUS, 2047);
        write_reg(REG_CENTER_SHIFT, 0);
        write_reg(REG_RADIUS_SHIFT, 0);
        add_points(pack_points(340, 300, 300, 340, 260, 300));
        add_points(pack_points(500, 500, 501, 500, 500, 501));
        queue_random(200);
        drain();

        write_reg(REG_MIN_RADIUS, 1023);
        write_reg(REG_MAX_RADIUS, 1023);
        write_reg(REG_CENTER_SHIFT, 7);
        write_reg(REG_RADIUS_SHIFT, 7);
        queue_random(50);
        drain();

        write_reg(REG_MIN_RADIUS, 40);
        write_reg(REG_MAX_RADIUS, 41);
        queue_random(30);
        drain();

        write_reg(REG_MIN_RADIUS, 5);
        write_reg(REG_MAX_RADIUS, 1500);
        write_reg(REG_CENTER_SHIFT, 6);
        write_reg(REG_RADIUS_SHIFT, 2);
        // A stretch with no idling at all.
        idle_on = 1'b0;
        queue_random(250);
        drain();
        idle_on = 1'b1;

        // Receiver holds off while the sender keeps offering, filling the pipe.
        hold_reqs = hold_reqs + 1;
        queue_random(200);
        drain();

        write_reg(REG_MIN_RADIUS, 10);
        write_reg(REG_MAX_RADIUS, 700);
        write_reg(REG_CENTER_SHIFT, 1);
        write_reg(REG_RADIUS_SHIFT, 5);
        for (k = 0; k < 250; k++) begin
            add_points(random_points());
        end
        drain();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
